[rtl/dptdc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dptdc_pkg
// Shared types and constants of the date-pair text to day-code block.
// ----------------------------------------------------------------------------
package dptdc_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned DayW   = 7;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 5;
  localparam int unsigned LetW   = 24;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned FullYW = 16;
  localparam int unsigned MoffW  = 9;

  localparam logic [CountW-1:0] SepPos   = 5'd9;
  localparam logic [CountW-1:0] SecStart = 5'd10;
  localparam logic [CountW-1:0] TextLen  = 5'd19;
  localparam logic [CountW-1:0] CountMax = 5'd20;

  // day number arithmetic
  localparam int unsigned RW       = 27;
  localparam int unsigned AccW     = 26;
  localparam int unsigned Q100W    = 10;
  localparam int unsigned RecipW   = 17;
  localparam int unsigned RecipSh  = 23;
  localparam logic [RecipW-1:0] Recip100 = 17'd83887;  // ceil(2^23 / 100)
  localparam int unsigned Day2006  = 732312;
  localparam int unsigned DayBias  = 306;

  typedef struct packed {
    logic [CharW-1:0] char_in;
    logic             last_char;
  } in_word_t;

  typedef struct packed {
    logic [CodeW-1:0] first_date_code;
    logic [CodeW-1:0] second_date_code;
    logic             bad_length;
  } out_word_t;

  typedef enum logic [1:0] {
    JobFirst,
    JobSecond,
    JobBad
  } job_kind_e;

  typedef struct packed {
    job_kind_e         kind;
    logic [DayW-1:0]   day;
    logic [MonW-1:0]   month;
    logic [YearW-1:0]  year;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_slot_t;

  // packed upper-case month code to month number, 0 when unknown
  function automatic logic [MonW-1:0] month_number(input logic [LetW-1:0] letters);
    logic [MonW-1:0] m;
    unique case (letters)
      24'h4A414E: m = 4'd1;
      24'h464542: m = 4'd2;
      24'h4D4152: m = 4'd3;
      24'h415052: m = 4'd4;
      24'h4D4159: m = 4'd5;
      24'h4A554E: m = 4'd6;
      24'h4A554C: m = 4'd7;
      24'h415547: m = 4'd8;
      24'h534550: m = 4'd9;
      24'h4F4354: m = 4'd10;
      24'h4E4F56: m = 4'd11;
      24'h444543: m = 4'd12;
      default:    m = 4'd0;
    endcase
    return m;
  endfunction

  // (153*m - 457)/5 for the shifted month 3..14
  function automatic logic [MoffW-1:0] month_offset(input logic [MonW-1:0] m);
    logic [MoffW-1:0] o;
    unique case (m)
      4'd4:    o = 9'd31;
      4'd5:    o = 9'd61;
      4'd6:    o = 9'd92;
      4'd7:    o = 9'd122;
      4'd8:    o = 9'd153;
      4'd9:    o = 9'd184;
      4'd10:   o = 9'd214;
      4'd11:   o = 9'd245;
      4'd12:   o = 9'd275;
      4'd13:   o = 9'd306;
      4'd14:   o = 9'd337;
      default: o = 9'd0;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

[rtl/dptdc_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dptdc_in_if
// Character channel: valid/ready handshake, one character word per transfer.
// ----------------------------------------------------------------------------
interface dptdc_in_if;
  import dptdc_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/dptdc_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dptdc_out_if
// Result channel: valid/ready handshake, two day codes and a length flag.
// ----------------------------------------------------------------------------
interface dptdc_out_if;
  import dptdc_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/dptdc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dptdc_front
// Character parser: gathers day, month and year fields and issues a date job
// on the separator and on the final character.
// ----------------------------------------------------------------------------
module dptdc_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  dptdc_in_if.sink                   in_i,
  input  wire logic                  full_i,
  output dptdc_pkg::job_slot_t       push_o
);
  import dptdc_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic [DayW-1:0]   day_q, day_d, day_n;
  logic [LetW-1:0]   let_q, let_d, let_n;
  logic [YearW-1:0]  year_q, year_d, year_n;
  logic              stop_q, stop_d, stop_n;
  logic [CountW-1:0] rel;
  logic              acc, is_dig;
  logic [3:0]        dval;

  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && !full_i;
  assign is_dig     = (in_i.data.char_in >= 8'h30) && (in_i.data.char_in <= 8'h39);
  assign dval       = in_i.data.char_in[3:0];
  assign rel        = (count_q < SepPos) ? count_q : count_q - SecStart;

  // field update for the current character
  always_comb begin
    day_n  = day_q;
    let_n  = let_q;
    year_n = year_q;
    stop_n = stop_q;
    if (count_q != SepPos && count_q < TextLen) begin
      if (rel == 5'd0 || rel == 5'd5) begin
        stop_n = 1'b0;
      end
      if (rel < 5'd2) begin
        if (!stop_n && is_dig) begin
          day_n = DayW'((DayW+4)'(day_q) * (DayW+4)'(10) + (DayW+4)'(dval));
        end else begin
          stop_n = 1'b1;
        end
      end else if (rel < 5'd5) begin
        let_n = {let_q[LetW-CharW-1:0], in_i.data.char_in};
      end else begin
        if (!stop_n && is_dig) begin
          year_n = YearW'((YearW+4)'(year_q) * (YearW+4)'(10) + (YearW+4)'(dval));
        end else begin
          stop_n = 1'b1;
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    day_d   = day_q;
    let_d   = let_q;
    year_d  = year_q;
    stop_d  = stop_q;
    push_o  = '0;
    if (acc) begin
      if (count_q < CountMax) begin
        count_d = count_q + 5'd1;
      end
      if (count_q == SepPos) begin
        push_o.valid     = 1'b1;
        push_o.job.kind  = JobFirst;
        push_o.job.day   = day_q;
        push_o.job.month = month_number(let_q);
        push_o.job.year  = year_q;
        day_d  = '0;
        let_d  = '0;
        year_d = '0;
        stop_d = 1'b0;
      end else begin
        day_d  = day_n;
        let_d  = let_n;
        year_d = year_n;
        stop_d = stop_n;
      end
      if (in_i.data.last_char) begin
        push_o.valid     = 1'b1;
        push_o.job.kind  = (count_d == TextLen) ? JobSecond : JobBad;
        push_o.job.day   = day_n;
        push_o.job.month = month_number(let_n);
        push_o.job.year  = year_n;
        count_d = '0;
        day_d   = '0;
        let_d   = '0;
        year_d  = '0;
        stop_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      day_q   <= '0;
      let_q   <= '0;
      year_q  <= '0;
      stop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      day_q   <= day_d;
      let_q   <= let_d;
      year_q  <= year_d;
      stop_q  <= stop_d;
    end
  end

endmodule
`default_nettype wire

[rtl/dptdc_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dptdc_queue
// Two-entry job queue between the parser and the day-code pipeline.
// ----------------------------------------------------------------------------
module dptdc_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dptdc_pkg::job_slot_t  push_i,
  input  wire logic                  pop_i,
  output dptdc_pkg::job_slot_t       head_o,
  output logic                       full_o
);
  import dptdc_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o       = (cnt_q == 2'd2);
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && (cnt_q != 2'd0);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.job   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

[rtl/dptdc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dptdc_back
// Day-code pipeline: civil date to day number to window code, four stages,
// then the result register. Holds the first code until the second arrives.
// ----------------------------------------------------------------------------
module dptdc_back #(
  parameter int unsigned CODE_WIDTH = 14
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dptdc_pkg::job_slot_t  head_i,
  output logic                       pop_o,
  dptdc_out_if.source                out_o
);
  import dptdc_pkg::*;

  localparam logic signed [RW-1:0] WinStart = RW'(Day2006);
  localparam logic signed [RW-1:0] WinEnd   = RW'(Day2006 + (1 << CODE_WIDTH) - 2);

  logic en;

  // stage 1: year and month shift, month offset
  logic               s1_v_q;
  job_kind_e          s1_kind_q;
  logic [FullYW-1:0]  s1_y_q, y_w;
  logic [MoffW-1:0]   s1_moff_q;
  logic [DayW-1:0]    s1_day_q;
  logic [MonW-1:0]    m_w;

  // stage 2: products
  logic               s2_v_q;
  job_kind_e          s2_kind_q;
  logic [AccW-2:0]    s2_p365_q;
  logic [YearW-1:0]   s2_q4_q;
  logic [Q100W-1:0]   s2_q100_q;
  logic [MoffW-1:0]   s2_moff_q;
  logic [DayW-1:0]    s2_day_q;
  logic [FullYW+RecipW-1:0] prod100;

  // stage 3: partial sums
  logic                     s3_v_q;
  job_kind_e                s3_kind_q;
  logic [AccW-1:0]          s3_a_q;
  logic signed [MoffW+1:0]  s3_b_q;

  // stage 4: day number
  logic                   s4_v_q;
  job_kind_e              s4_kind_q;
  logic signed [RW-1:0]   s4_r_q;

  logic [CodeW-1:0]     held_q;
  logic                 ov_q, ov_d;
  out_word_t            od_q, od_d;
  logic [CodeW-1:0]     code;
  logic signed [RW-1:0] diff;

  assign en    = !ov_q || out_o.ready;
  assign pop_o = en;

  always_comb begin
    if (head_i.job.month < 4'd3) begin
      y_w = FullYW'(head_i.job.year) - 16'd1;
      m_w = head_i.job.month + 4'd12;
    end else begin
      y_w = FullYW'(head_i.job.year);
      m_w = head_i.job.month;
    end
  end

  assign prod100 = (FullYW+RecipW)'(s1_y_q) * (FullYW+RecipW)'(Recip100);

  // window mapping
  assign diff = s4_r_q - WinStart + RW'(2);
  always_comb begin
    if (s4_r_q < 0) begin
      code = '1;
    end else if (s4_r_q < WinStart) begin
      code = 16'd1;
    end else if (s4_r_q > WinEnd) begin
      code = '1;
    end else begin
      code = CodeW'(diff[CODE_WIDTH:0]);
    end
  end

  always_comb begin
    ov_d = ov_q;
    od_d = od_q;
    if (en) begin
      ov_d = s4_v_q && (s4_kind_q != JobFirst);
      case (s4_kind_q)
        JobSecond: begin
          od_d.first_date_code  = held_q;
          od_d.second_date_code = code;
          od_d.bad_length       = 1'b0;
        end
        default: begin
          od_d = '0;
          od_d.bad_length = 1'b1;
        end
      endcase
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = od_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_kind_q <= head_i.job.kind;
      s1_y_q    <= y_w;
      s1_moff_q <= month_offset(m_w);
      s1_day_q  <= head_i.job.day;

      s2_kind_q <= s1_kind_q;
      s2_p365_q <= (AccW-1)'((AccW-1)'(s1_y_q) * (AccW-1)'(365));
      s2_q4_q   <= s1_y_q[FullYW-1:2];
      s2_q100_q <= Q100W'(prod100 >> RecipSh);
      s2_moff_q <= s1_moff_q;
      s2_day_q  <= s1_day_q;

      s3_kind_q <= s2_kind_q;
      s3_a_q    <= AccW'(s2_p365_q) + AccW'(s2_q4_q) + AccW'(s2_q100_q >> 2)
                   - AccW'(s2_q100_q);
      s3_b_q    <= $signed((MoffW+2)'(s2_moff_q)) + $signed((MoffW+2)'(s2_day_q))
                   - $signed((MoffW+2)'(DayBias));

      s4_kind_q <= s3_kind_q;
      s4_r_q    <= $signed(RW'(s3_a_q)) + RW'(s3_b_q);

      od_q      <= od_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      ov_q   <= 1'b0;
      held_q <= '0;
    end else begin
      ov_q <= ov_d;
      if (en) begin
        s1_v_q <= head_i.valid;
        s2_v_q <= s1_v_q;
        s3_v_q <= s2_v_q;
        s4_v_q <= s3_v_q;
        if (s4_v_q && s4_kind_q == JobFirst) begin
          held_q <= code;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/date_pair_text_to_day_codes_core.sv]
`default_nettype none
// Path: a result word follows the final character through the queue, the four
//   day-code stages and the result register.
// Throughput: one character per cycle; while a result waits, input keeps flowing
//   until the two-entry job queue fills, then ready drops.
// Reset: asynchronous, active low; clears parser fields, queue and pipeline valids.
// ----------------------------------------------------------------------------
// date_pair_text_to_day_codes_core
// Parses a DDMMMYYYY?DDMMMYYYY character stream and returns two day codes.
// ----------------------------------------------------------------------------
module date_pair_text_to_day_codes_core #(
  parameter int unsigned CODE_WIDTH = 14
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  dptdc_in_if.sink     in_i,
  dptdc_out_if.source  out_o
);
  import dptdc_pkg::*;

  job_slot_t push;
  job_slot_t head;
  logic      full;
  logic      pop;

  dptdc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  dptdc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full)
  );

  dptdc_back #(
    .CODE_WIDTH (CODE_WIDTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire
